/* rtl/hscf_pkg.sv */
// Shared types and constants for the humidity sensor frame checker.
// Used by the front, the frame queue, the converter and the top level.
package hscf_pkg;

  // Frame queue depth and the widths that follow from it
  localparam int QueueDepth = 4;
  localparam int QueueAw    = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCw    = $clog2(QueueDepth + 1);

  // CRC-8 generator polynomial and seed
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Conversion to hundredths: span * raw / 65535, then minus offset
  localparam logic [14:0] TEMP_SPAN    = 15'd17500;
  localparam logic [14:0] TEMP_OFFSET  = 15'd4500;
  localparam logic [14:0] HUMID_SPAN   = 15'd12500;
  localparam logic [14:0] HUMID_OFFSET = 15'd600;

  // One checked frame, handed from the front to the converter
  typedef struct packed {
    logic        temp_ok;
    logic        humid_ok;
    logic [15:0] raw_temp;
    logic [15:0] raw_humid;
  } frame_rec_t;

endpackage

/* rtl/hscf_front.sv */
// Byte front end: tracks the frame position, runs the CRC-8 over each word
// and emits one frame record after the sixth byte. Depends on hscf_pkg.
module hscf_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          data_byte,
  input  logic                frame_start,
  input  logic                queue_full,
  output logic                push,
  output hscf_pkg::frame_rec_t push_rec
);

  // Frame position, one bit per byte slot
  typedef enum logic [5:0] {
    POS_T_MSB = 6'b000001,
    POS_T_LSB = 6'b000010,
    POS_T_CRC = 6'b000100,
    POS_H_MSB = 6'b001000,
    POS_H_LSB = 6'b010000,
    POS_H_CRC = 6'b100000
  } pos_t;

  pos_t        pos, pos_next, pos_eff;
  logic [7:0]  running_crc, running_crc_next;
  logic [7:0]  word_high, word_high_next;
  logic [7:0]  word_low, word_low_next;
  logic [15:0] held_temp, held_temp_next;
  logic        held_temp_ok, held_temp_ok_next;
  logic        accept;

  // Feed one byte through the CRC, MSB first
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ hscf_pkg::CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // Hold off bytes while the queue has no room
  assign in_stall = queue_full;
  assign accept   = in_valid & ~queue_full;

  // Decode the current byte against the frame position
  always_comb begin
    pos_eff           = frame_start ? POS_T_MSB : pos;
    pos_next          = pos;
    running_crc_next  = running_crc;
    word_high_next    = word_high;
    word_low_next     = word_low;
    held_temp_next    = held_temp;
    held_temp_ok_next = held_temp_ok;
    push              = 1'b0;
    push_rec.temp_ok   = held_temp_ok;
    push_rec.humid_ok  = (running_crc == data_byte);
    push_rec.raw_temp  = held_temp;
    push_rec.raw_humid = {word_high, word_low};
    if (accept) begin
      case (pos_eff)
        POS_T_MSB: begin
          running_crc_next = crc8_feed(hscf_pkg::CRC_INIT, data_byte);
          word_high_next   = data_byte;
          pos_next         = POS_T_LSB;
        end
        POS_T_LSB: begin
          running_crc_next = crc8_feed(running_crc, data_byte);
          held_temp_next   = {word_high, data_byte};
          pos_next         = POS_T_CRC;
        end
        POS_T_CRC: begin
          held_temp_ok_next = (running_crc == data_byte);
          running_crc_next  = hscf_pkg::CRC_INIT;
          pos_next          = POS_H_MSB;
        end
        POS_H_MSB: begin
          running_crc_next = crc8_feed(hscf_pkg::CRC_INIT, data_byte);
          word_high_next   = data_byte;
          pos_next         = POS_H_LSB;
        end
        POS_H_LSB: begin
          running_crc_next = crc8_feed(running_crc, data_byte);
          word_low_next    = data_byte;
          pos_next         = POS_H_CRC;
        end
        POS_H_CRC: begin
          push             = 1'b1;
          running_crc_next = hscf_pkg::CRC_INIT;
          pos_next         = POS_T_MSB;
        end
        default: begin
          // Unknown position code: restart as the first byte
          running_crc_next = crc8_feed(hscf_pkg::CRC_INIT, data_byte);
          word_high_next   = data_byte;
          pos_next         = POS_T_LSB;
        end
      endcase
    end
  end

  // Advance the frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= POS_T_MSB;
      running_crc  <= hscf_pkg::CRC_INIT;
      word_high    <= 8'd0;
      word_low     <= 8'd0;
      held_temp    <= 16'd0;
      held_temp_ok <= 1'b0;
    end else begin
      pos          <= pos_next;
      running_crc  <= running_crc_next;
      word_high    <= word_high_next;
      word_low     <= word_low_next;
      held_temp    <= held_temp_next;
      held_temp_ok <= held_temp_ok_next;
    end
  end

`ifndef SYNTH
  // A completed frame always returns the position to the first byte
  a_push_restarts: assert property (@(posedge clk) disable iff (rst)
    push |=> (pos == POS_T_MSB && running_crc == hscf_pkg::CRC_INIT))
    else $error("front: position not restarted after frame");
`endif

endmodule

/* rtl/hscf_queue.sv */
// Short frame queue between the byte front end and the converter.
// Register array with read and write pointers. Depends on hscf_pkg.
module hscf_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  hscf_pkg::frame_rec_t push_rec,
  output logic                 full,
  input  logic                 pop,
  output logic                 pop_valid,
  output hscf_pkg::frame_rec_t pop_rec
);

  hscf_pkg::frame_rec_t             slots [hscf_pkg::QueueDepth];
  logic [hscf_pkg::QueueAw-1:0]     wr_ptr, rd_ptr;
  logic [hscf_pkg::QueueCw-1:0]     count;
  logic                             do_push, do_pop;

  localparam logic [hscf_pkg::QueueAw-1:0] LAST = hscf_pkg::QueueAw'(hscf_pkg::QueueDepth - 1);
  localparam logic [hscf_pkg::QueueCw-1:0] FULL = hscf_pkg::QueueCw'(hscf_pkg::QueueDepth);

  assign full      = (count == FULL);
  assign pop_valid = (count != '0);
  assign pop_rec   = slots[rd_ptr];
  assign do_push   = push & ~full;
  assign do_pop    = pop & pop_valid;

  // Store incoming frame
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("queue: fill count beyond depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("queue: push while full");
`endif

endmodule

/* rtl/hscf_conv.sv */
// Back end: converts raw words to hundredths in a three-stage pipeline
// (multiply, divide by 65535, offset) and holds the result word. Uses hscf_pkg.
module hscf_conv (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  hscf_pkg::frame_rec_t q_rec,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 frame_ok,
  output logic                 temp_crc_ok,
  output logic                 humid_crc_ok,
  output logic [15:0]          raw_temp,
  output logic [15:0]          raw_humid,
  output logic signed [14:0]   temp_centi,
  output logic signed [14:0]   humid_centi
);

  logic                 en;
  logic                 v1, v2;
  hscf_pkg::frame_rec_t rec1, rec2;
  logic [30:0]          prod_t, prod_h;
  logic [14:0]          quo_t, quo_h;

  // Exact floor(x / 65535) for x below 65535 * 32768
  function automatic logic [14:0] div_65535(input logic [30:0] x);
    logic [31:0] s;
    s = {1'b0, x} + {17'd0, x[30:16]} + 32'd1;
    return s[30:16];
  endfunction

  // Move the whole pipe when the output word is free or being taken
  assign en  = ~out_valid | ~out_stall;
  assign pop = q_valid & en;

  // Stage one: constant multiplies
  always_ff @(posedge clk) begin
    if (en) begin
      rec1   <= q_rec;
      prod_t <= 31'(q_rec.raw_temp) * 31'(hscf_pkg::TEMP_SPAN);
      prod_h <= 31'(q_rec.raw_humid) * 31'(hscf_pkg::HUMID_SPAN);
    end
  end

  // Stage two: divide by 65535
  always_ff @(posedge clk) begin
    if (en) begin
      rec2  <= rec1;
      quo_t <= div_65535(prod_t);
      quo_h <= div_65535(prod_h);
    end
  end

  // Output word: apply offsets, hold while stalled
  always_ff @(posedge clk) begin
    if (en) begin
      frame_ok     <= rec2.temp_ok & rec2.humid_ok;
      temp_crc_ok  <= rec2.temp_ok;
      humid_crc_ok <= rec2.humid_ok;
      raw_temp     <= rec2.raw_temp;
      raw_humid    <= rec2.raw_humid;
      temp_centi   <= $signed(quo_t - hscf_pkg::TEMP_OFFSET);
      humid_centi  <= $signed(quo_h - hscf_pkg::HUMID_OFFSET);
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= q_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

`ifndef SYNTH
  a_pop_fills_s1: assert property (@(posedge clk) disable iff (rst)
    pop |=> v1)
    else $error("conv: popped frame lost before stage one");
  a_s2_reaches_out: assert property (@(posedge clk) disable iff (rst)
    (v2 && en) |=> out_valid)
    else $error("conv: stage two word not delivered to output");
`endif

endmodule

/* rtl/humidity_sensor_frame_check_top.sv */
// Top level of the humidity sensor frame checker.
// Instantiates hscf_front, hscf_queue and hscf_conv; uses hscf_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) takes the response bytes in order:
//   temperature MSB, LSB, CRC, humidity MSB, LSB, CRC. frame_start marks a
//   first byte and drops any partial frame. After a complete frame the
//   position wraps, so the next byte starts a new frame on its own.
//   Output channel (out_valid / out_stall) gives one result word per frame:
//   both raw words, both CRC verdicts and the values in hundredths.
//   Throughput: one byte per cycle while in_stall is low.
//   After the edge that takes the sixth byte the frame is popped from the
//   queue and registered by the multiply, divide by 65535 and offset stages.
//   The front end and the converter are parted by a four-frame queue; when
//   out_stall holds a waiting result word the converter pipeline holds, the
//   queue fills, and in_stall rises only once the queue is full.
//   Reset (rst, synchronous) restarts the frame position and CRC, empties
//   the queue and clears all pipeline valid bits.
module humidity_sensor_frame_check_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          data_byte,
  input  logic                frame_start,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                frame_ok,
  output logic                temp_crc_ok,
  output logic                humid_crc_ok,
  output logic [15:0]         raw_temp,
  output logic [15:0]         raw_humid,
  output logic signed [14:0]  temp_centi,
  output logic signed [14:0]  humid_centi
);

  logic                 push, queue_full, pop, q_valid;
  hscf_pkg::frame_rec_t push_rec, q_rec;

  // Classify bytes and check CRCs
  hscf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .queue_full  (queue_full),
    .push        (push),
    .push_rec    (push_rec)
  );

  // Buffer checked frames
  hscf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_rec  (push_rec),
    .full      (queue_full),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_rec   (q_rec)
  );

  // Convert and deliver results
  hscf_conv u_conv (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_rec        (q_rec),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_ok     (frame_ok),
    .temp_crc_ok  (temp_crc_ok),
    .humid_crc_ok (humid_crc_ok),
    .raw_temp     (raw_temp),
    .raw_humid    (raw_humid),
    .temp_centi   (temp_centi),
    .humid_centi  (humid_centi)
  );

endmodule

/* sim/humidity_sensor_frame_check_top_test.sv */
// Self-checking bench for humidity_sensor_frame_check_top.
// Feeds sensor response bytes, tracks the CRC-8 frame and conversion in step,
// and compares every result word field by field; depends on hscf_pkg and the top.
`timescale 1ns / 100ps

module humidity_sensor_frame_check_top_test;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int BYTE_TARGET  = 900;
  localparam int SETTLE_TICKS = 8;
  localparam int LONG_HOLD    = 400;

  // Byte positions inside one response frame
  localparam logic [2:0] POS_T_MSB = 3'd0;
  localparam logic [2:0] POS_T_LSB = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_MSB = 3'd3;
  localparam logic [2:0] POS_H_LSB = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  typedef struct {
    logic [7:0] data;
    logic       start;
    logic       drain;  // wait for all results before offering this byte
  } byte_item_t;

  typedef struct {
    logic               frame_ok;
    logic               temp_ok;
    logic               humid_ok;
    logic [15:0]        raw_temp;
    logic [15:0]        raw_humid;
    logic signed [14:0] temp_centi;
    logic signed [14:0] humid_centi;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic frame_start = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic frame_ok;
  logic temp_crc_ok;
  logic humid_crc_ok;
  logic [15:0] raw_temp;
  logic [15:0] raw_humid;
  logic signed [14:0] temp_centi;
  logic signed [14:0] humid_centi;

  byte_item_t    pending_bytes[$];
  frame_result_t frames_due[$];

  // Tracked frame state
  logic [2:0]  next_pos = POS_T_MSB;
  logic [7:0]  crc_run = hscf_pkg::CRC_INIT;
  logic [7:0]  msb_hold = 8'h00;
  logic [7:0]  lsb_hold = 8'h00;
  logic [15:0] temp_word = 16'h0000;
  logic        temp_good = 1'b0;

  int fail_count = 0;
  int cycle_count = 0;
  int sent_count = 0;
  int gap_left = 0;
  int results_seen = 0;
  int good_frames = 0;
  int bad_frames = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;

  humidity_sensor_frame_check_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .frame_start  (frame_start),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_ok     (frame_ok),
    .temp_crc_ok  (temp_crc_ok),
    .humid_crc_ok (humid_crc_ok),
    .raw_temp     (raw_temp),
    .raw_humid    (raw_humid),
    .temp_centi   (temp_centi),
    .humid_centi  (humid_centi)
  );

  always #5 clk = ~clk;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    int i;
    c = crc ^ b;
    for (i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ hscf_pkg::CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] word_crc(logic [15:0] w);
    return crc8_step(crc8_step(hscf_pkg::CRC_INIT, w[15:8]), w[7:0]);
  endfunction

  // Scale a raw word to hundredths with a floor divide, then remove the offset
  function automatic logic signed [14:0] to_hundredths(logic [15:0] raw,
                                                       logic [14:0] span,
                                                       logic [14:0] offset);
    int q;
    q = (int'(span) * int'(raw)) / 65535;
    return 15'(q - int'(offset));
  endfunction

  // Advance the tracked frame by one accepted byte; queue a result on byte six
  task automatic decode_frame_byte(logic [7:0] b, logic fs);
    logic [2:0] pos;
    logic [15:0] hum;
    logic hok;
    frame_result_t r;
    pos = fs ? POS_T_MSB : next_pos;
    if (pos > POS_H_CRC) pos = POS_T_MSB;
    case (pos)
      POS_T_MSB, POS_H_MSB: begin
        crc_run = crc8_step(hscf_pkg::CRC_INIT, b);
        msb_hold = b;
        next_pos = pos + 3'd1;
      end
      POS_T_LSB: begin
        crc_run = crc8_step(crc_run, b);
        temp_word = {msb_hold, b};
        next_pos = POS_T_CRC;
      end
      POS_T_CRC: begin
        temp_good = (crc_run == b);
        crc_run = hscf_pkg::CRC_INIT;
        next_pos = POS_H_MSB;
      end
      POS_H_LSB: begin
        crc_run = crc8_step(crc_run, b);
        lsb_hold = b;
        next_pos = POS_H_CRC;
      end
      default: begin
        hum = {msb_hold, lsb_hold};
        hok = (crc_run == b);
        r.frame_ok = temp_good & hok;
        r.temp_ok = temp_good;
        r.humid_ok = hok;
        r.raw_temp = temp_word;
        r.raw_humid = hum;
        r.temp_centi = to_hundredths(temp_word, hscf_pkg::TEMP_SPAN,
                                     hscf_pkg::TEMP_OFFSET);
        r.humid_centi = to_hundredths(hum, hscf_pkg::HUMID_SPAN,
                                      hscf_pkg::HUMID_OFFSET);
        frames_due.push_back(r);
        crc_run = hscf_pkg::CRC_INIT;
        next_pos = POS_T_MSB;
      end
    endcase
  endtask

  task automatic add_byte(logic [7:0] b, logic fs, logic drain);
    byte_item_t it;
    it.data = b;
    it.start = fs;
    it.drain = drain;
    pending_bytes.push_back(it);
  endtask

  // Queue one full frame; a bad CRC is the right one with some bits flipped
  task automatic add_frame(logic [15:0] t, logic [15:0] h, logic fs,
                           logic t_good, logic h_good, logic drain);
    logic [7:0] tc;
    logic [7:0] hc;
    tc = word_crc(t) ^ (t_good ? 8'h00 : 8'($urandom_range(1, 255)));
    hc = word_crc(h) ^ (h_good ? 8'h00 : 8'($urandom_range(1, 255)));
    add_byte(t[15:8], fs, drain);
    add_byte(t[7:0], 1'b0, 1'b0);
    add_byte(tc, 1'b0, 1'b0);
    add_byte(h[15:8], 1'b0, 1'b0);
    add_byte(h[7:0], 1'b0, 1'b0);
    add_byte(hc, 1'b0, 1'b0);
  endtask

  function automatic logic [15:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'h0000;
    if (r < 16) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Drive bytes from the pending queue, with random gaps and drain points
  always @(posedge clk) begin : feed_bytes
    bit held;
    bit quiet;
    byte_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      held = in_valid && in_stall;
      quiet = ((sent_count / 150) % 4) == 2;
      if (in_valid && !in_stall) begin
        decode_frame_byte(data_byte, frame_start);
        sent_count++;
      end
      if (!held) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0 &&
                     !(pending_bytes[0].drain && frames_due.size() > 0)) begin
          nxt = pending_bytes.pop_front();
          in_valid <= 1'b1;
          data_byte <= nxt.data;
          frame_start <= nxt.start;
          gap_left = quiet ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Take result words, check them, and stall the output side
  always @(posedge clk) begin : take_results
    int r;
    bit calm;
    frame_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (frames_due.size() == 0) begin
          $error("result word with no frame pending");
          fail_count++;
        end else begin
          want = frames_due.pop_front();
          check_field("frame_ok", want.frame_ok, frame_ok);
          check_field("temp_crc_ok", want.temp_ok, temp_crc_ok);
          check_field("humid_crc_ok", want.humid_ok, humid_crc_ok);
          check_field("raw_temp", want.raw_temp, raw_temp);
          check_field("raw_humid", want.raw_humid, raw_humid);
          check_field("temp_centi", int'(want.temp_centi), int'(temp_centi));
          check_field("humid_centi", int'(want.humid_centi), int'(humid_centi));
          results_seen++;
          if (want.frame_ok) good_frames++;
          else bad_frames++;
        end
      end
      calm = ((results_seen / 20) % 4) == 1;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!long_hold_done && results_seen >= 30) begin
        // hold off long enough for the frame queue to fill and back up
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
        out_stall <= 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_stall <= 1'b0;
        end else begin
          out_stall <= 1'b1;
          hold_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int r;
    int n;
    int frame_no;
    bit force_start;
    // both words at their minimum, then at their maximum with no frame start
    add_frame(16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b0);
    add_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b0);
    // temperature CRC wrong, humidity right
    add_frame(16'hBEEF, 16'h8000, 1'b1, 1'b0, 1'b1, 1'b0);
    // partial frame dropped by a new frame start, then humidity CRC wrong
    add_byte(8'h66, 1'b1, 1'b1);
    add_byte(8'h93, 1'b0, 1'b0);
    add_byte(8'h5A, 1'b0, 1'b0);
    add_frame(16'h1234, 16'hABCD, 1'b1, 1'b1, 1'b0, 1'b0);

    // random frames with some partial frames and stray bytes mixed in
    frame_no = 0;
    force_start = 1'b1;
    while (pending_bytes.size() < BYTE_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        add_frame(pick_word(), pick_word(),
                  force_start | 1'($urandom_range(0, 1)),
                  $urandom_range(0, 99) < 75, $urandom_range(0, 99) < 75,
                  frame_no == 70);
        frame_no++;
        force_start = 1'b0;
      end else if (r < 90) begin
        n = $urandom_range(1, 5);
        add_byte(8'($urandom), 1'b1, 1'b0);
        repeat (n - 1) add_byte(8'($urandom), 1'b0, 1'b0);
        force_start = $urandom_range(0, 99) < 80;
      end else begin
        add_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
        force_start = 1'b1;
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || in_valid || frames_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);

    $display("sent %0d bytes, checked %0d frames in %0d cycles",
             sent_count, results_seen, cycle_count);
    $display("frames with both CRCs good: %0d, with a CRC failure: %0d",
             good_frames, bad_frames);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
